### rtl/erpg_pkg.sv
// Shared types, constants and a helper function of the Euclidean rhythm generator.
`timescale 1ns / 1ps

package erpg_pkg;

   // Longest pattern the block builds; longer requests saturate to it.
   localparam int MAX_STEPS = 16;

   // Widths of the request fields and of the result fields.
   localparam int FIELD_W   = 5;
   localparam int PATTERN_W = 16;
   localparam int CODE_W    = 4;

   // Width of a group size (1..16) and of a bit index inside a group.
   localparam int SIZE_W    = 5;
   localparam int INDEX_W   = 4;

   // The product count1 * size1 stays at or below 16 * 16.
   localparam int PROD_W    = 9;
   localparam int NUM_W     = 10;

   // A non-negative dividend never exceeds 15, so four quotient bits suffice.
   localparam int DIV_BITS  = 4;
   localparam int DIVCNT_W  = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODROT,
      ST_MULT,
      ST_DIVSET,
      ST_DIVIDE,
      ST_UPDATE,
      ST_EMIT,
      ST_FINISH
   } erpg_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic rot_step;
      logic mul;
      logic div_init;
      logic div_step;
      logic update;
      logic emit_init;
      logic emit_step;
      logic out_load;
   } erpg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rot_ok;
      logic div_last;
      logic stop;
      logic emit_done;
      logic out_free;
   } erpg_sts_type;

   // Position of the highest set bit, at least 1.
   function automatic logic [SIZE_W-1:0] bit_len(input logic [PATTERN_W-1:0] grp);
      logic [SIZE_W-1:0] n;
      n = SIZE_W'(1);
      for (int i = 0; i < PATTERN_W; i++) begin
         if (grp[i]) begin
            n = SIZE_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

### rtl/erpg_ctrl.sv
// Controller state machine that sequences the rhythm build.
`timescale 1ns / 1ps

module erpg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  erpg_pkg::erpg_sts_type sts,
   output erpg_pkg::erpg_cmd_type cmd,
   output logic                  idle
);

   erpg_pkg::erpg_state_type state_ff;
   erpg_pkg::erpg_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         erpg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = erpg_pkg::ST_MODROT;
            end
         end
         erpg_pkg::ST_MODROT: begin
            if (sts.rot_ok) begin
               state_in = erpg_pkg::ST_MULT;
            end
         end
         erpg_pkg::ST_MULT: begin
            state_in = erpg_pkg::ST_DIVSET;
         end
         erpg_pkg::ST_DIVSET: begin
            state_in = erpg_pkg::ST_DIVIDE;
         end
         erpg_pkg::ST_DIVIDE: begin
            if (sts.div_last) begin
               state_in = erpg_pkg::ST_UPDATE;
            end
         end
         erpg_pkg::ST_UPDATE: begin
            state_in = sts.stop ? erpg_pkg::ST_EMIT : erpg_pkg::ST_MULT;
         end
         erpg_pkg::ST_EMIT: begin
            if (sts.emit_done) begin
               state_in = erpg_pkg::ST_FINISH;
            end
         end
         erpg_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = erpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = erpg_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd  = '0;
      idle = 1'b0;
      case (state_ff)
         erpg_pkg::ST_IDLE: begin
            idle     = 1'b1;
            cmd.load = req_valid;
         end
         erpg_pkg::ST_MODROT: begin
            cmd.rot_step = 1'b1;
         end
         erpg_pkg::ST_MULT: begin
            cmd.mul = 1'b1;
         end
         erpg_pkg::ST_DIVSET: begin
            cmd.div_init = 1'b1;
         end
         erpg_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         erpg_pkg::ST_UPDATE: begin
            cmd.update    = !sts.stop;
            cmd.emit_init = sts.stop;
         end
         erpg_pkg::ST_EMIT: begin
            cmd.emit_step = !sts.emit_done;
         end
         erpg_pkg::ST_FINISH: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/erpg_datapath.sv
// Datapath: rotation reduction, group merging, division, serialization and result register.
`timescale 1ns / 1ps

module erpg_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  erpg_pkg::erpg_cmd_type           cmd,
   output erpg_pkg::erpg_sts_type           sts,
   input  logic [erpg_pkg::FIELD_W-1:0]     req_pattern_length,
   input  logic [erpg_pkg::FIELD_W-1:0]     req_pulse_count,
   input  logic [erpg_pkg::FIELD_W-1:0]     req_rotation,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [erpg_pkg::PATTERN_W-1:0]   rsp_pattern_bits,
   output logic [erpg_pkg::CODE_W-1:0]      rsp_length_code
);

   localparam logic [erpg_pkg::FIELD_W-1:0] MaxLen = erpg_pkg::FIELD_W'(erpg_pkg::MAX_STEPS);
   localparam int DIV_W = erpg_pkg::DIV_BITS;

   logic [erpg_pkg::FIELD_W-1:0]   len_ff, len_in;
   logic [erpg_pkg::FIELD_W-1:0]   rot_ff, rot_in;
   logic [erpg_pkg::FIELD_W-1:0]   cnt1_ff, cnt1_in;
   logic [erpg_pkg::FIELD_W-1:0]   round_ff, round_in;
   logic [erpg_pkg::PATTERN_W-1:0] g1_ff, g1_in;
   logic [erpg_pkg::PATTERN_W-1:0] g2_ff, g2_in;
   logic [erpg_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic                           neg_ff, neg_in;
   logic [DIV_W-1:0]               quo_ff, quo_in;
   logic [DIV_W-1:0]               rem_ff, rem_in;
   logic [erpg_pkg::DIVCNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [DIV_W-1:0]               cnt2_ff, cnt2_in;
   logic [erpg_pkg::FIELD_W-1:0]   pos_ff, pos_in;
   logic [erpg_pkg::INDEX_W-1:0]   wpos_ff, wpos_in;
   logic [erpg_pkg::FIELD_W-1:0]   copy_ff, copy_in;
   logic [erpg_pkg::INDEX_W-1:0]   bit_ff, bit_in;
   logic                           grp_ff, grp_in;
   logic [erpg_pkg::PATTERN_W-1:0] pat_ff, pat_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [erpg_pkg::PATTERN_W-1:0] rsp_pattern_ff, rsp_pattern_in;
   logic [erpg_pkg::CODE_W-1:0]    rsp_code_ff, rsp_code_in;

   logic [erpg_pkg::SIZE_W-1:0]      s1, s2, cur_s;
   logic [erpg_pkg::PATTERN_W-1:0]   cur_g;
   logic [2*erpg_pkg::FIELD_W-1:0]   prod_full;
   logic [erpg_pkg::NUM_W-1:0]       num;
   logic [DIV_W:0]                   rem_sh;
   logic [2*erpg_pkg::PATTERN_W-1:0] g1_shift;
   logic [erpg_pkg::FIELD_W-1:0]     req_len_c, req_pulse_c;

   assign s1    = erpg_pkg::bit_len(g1_ff);
   assign s2    = erpg_pkg::bit_len(g2_ff);
   assign cur_g = grp_ff ? g2_ff : g1_ff;
   assign cur_s = grp_ff ? s2 : s1;

   assign prod_full = (2*erpg_pkg::FIELD_W)'(cnt1_ff) * (2*erpg_pkg::FIELD_W)'(s1);
   assign num       = erpg_pkg::NUM_W'(len_ff) - erpg_pkg::NUM_W'(prod_ff);
   assign rem_sh    = {rem_ff, quo_ff[DIV_W-1]};
   assign g1_shift  = (2*erpg_pkg::PATTERN_W)'(g1_ff) << s2;

   always_comb begin
      req_len_c = req_pattern_length;
      if (req_len_c == '0) begin
         req_len_c = erpg_pkg::FIELD_W'(1);
      end else if (req_len_c > MaxLen) begin
         req_len_c = MaxLen;
      end
      req_pulse_c = req_pulse_count;
      if (req_pulse_c == '0) begin
         req_pulse_c = erpg_pkg::FIELD_W'(1);
      end else if (req_pulse_c > req_len_c) begin
         req_pulse_c = req_len_c;
      end
   end

   always_comb begin
      sts.rot_ok    = rot_ff < len_ff;
      sts.div_last  = div_cnt_ff == erpg_pkg::DIVCNT_W'(DIV_W - 1);
      sts.stop      = neg_ff || (quo_ff <= DIV_W'(1)) || (round_ff >= MaxLen);
      sts.emit_done = (copy_ff == '0) || (pos_ff == len_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      len_in         = len_ff;
      rot_in         = rot_ff;
      cnt1_in        = cnt1_ff;
      round_in       = round_ff;
      g1_in          = g1_ff;
      g2_in          = g2_ff;
      prod_in        = prod_ff;
      neg_in         = neg_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      cnt2_in        = cnt2_ff;
      pos_in         = pos_ff;
      wpos_in        = wpos_ff;
      copy_in        = copy_ff;
      bit_in         = bit_ff;
      grp_in         = grp_ff;
      pat_in         = pat_ff;
      rsp_pattern_in = rsp_pattern_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         len_in   = req_len_c;
         cnt1_in  = req_pulse_c;
         rot_in   = req_rotation;
         g1_in    = erpg_pkg::PATTERN_W'(1);
         g2_in    = '0;
         round_in = '0;
      end

      // One compare and subtract per cycle until the rotation is below the length.
      if (cmd.rot_step && !sts.rot_ok) begin
         rot_in = rot_ff - len_ff;
      end

      if (cmd.mul) begin
         prod_in = prod_full[erpg_pkg::PROD_W-1:0];
      end

      if (cmd.div_init) begin
         neg_in     = num[erpg_pkg::NUM_W-1];
         quo_in     = num[DIV_W-1:0];
         rem_in     = '0;
         div_cnt_in = '0;
      end

      // Restoring division, one quotient bit per cycle.
      if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + erpg_pkg::DIVCNT_W'(1);
         if (rem_sh >= (DIV_W+1)'(s2)) begin
            rem_in = DIV_W'(rem_sh - (DIV_W+1)'(s2));
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end

      // Merge round: append group 2 to group 1; quo_ff holds the second count here.
      if (cmd.update) begin
         g1_in    = g1_shift[erpg_pkg::PATTERN_W-1:0] | g2_ff;
         round_in = round_ff + erpg_pkg::FIELD_W'(1);
         if (erpg_pkg::FIELD_W'(quo_ff) <= cnt1_ff) begin
            g2_in = g1_ff;
         end
         if (erpg_pkg::FIELD_W'(quo_ff) < cnt1_ff) begin
            cnt1_in = erpg_pkg::FIELD_W'(quo_ff);
         end
      end

      if (cmd.emit_init) begin
         cnt2_in = neg_ff ? '0 : quo_ff;
         pos_in  = '0;
         wpos_in = rot_ff[erpg_pkg::INDEX_W-1:0];
         copy_in = cnt1_ff;
         bit_in  = erpg_pkg::INDEX_W'(s1 - erpg_pkg::SIZE_W'(1));
         grp_in  = 1'b0;
         pat_in  = '0;
      end

      // Serialization writes each step straight to its rotated position.
      if (cmd.emit_step) begin
         pat_in[wpos_ff] = pat_ff[wpos_ff] | cur_g[bit_ff];
         pos_in          = pos_ff + erpg_pkg::FIELD_W'(1);
         if (erpg_pkg::FIELD_W'(wpos_ff) == len_ff - erpg_pkg::FIELD_W'(1)) begin
            wpos_in = '0;
         end else begin
            wpos_in = wpos_ff + erpg_pkg::INDEX_W'(1);
         end
         if (bit_ff == '0) begin
            if (copy_ff == erpg_pkg::FIELD_W'(1)) begin
               if (!grp_ff && (cnt2_ff != '0)) begin
                  grp_in  = 1'b1;
                  copy_in = erpg_pkg::FIELD_W'(cnt2_ff);
                  bit_in  = erpg_pkg::INDEX_W'(s2 - erpg_pkg::SIZE_W'(1));
               end else begin
                  copy_in = '0;
               end
            end else begin
               copy_in = copy_ff - erpg_pkg::FIELD_W'(1);
               bit_in  = erpg_pkg::INDEX_W'(cur_s - erpg_pkg::SIZE_W'(1));
            end
         end else begin
            bit_in = bit_ff - erpg_pkg::INDEX_W'(1);
         end
      end

      if (cmd.out_load) begin
         rsp_pattern_in = pat_ff;
         rsp_code_in    = len_ff[erpg_pkg::CODE_W-1:0];
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff         <= len_in;
      rot_ff         <= rot_in;
      cnt1_ff        <= cnt1_in;
      round_ff       <= round_in;
      g1_ff          <= g1_in;
      g2_ff          <= g2_in;
      prod_ff        <= prod_in;
      neg_ff         <= neg_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      div_cnt_ff     <= div_cnt_in;
      cnt2_ff        <= cnt2_in;
      pos_ff         <= pos_in;
      wpos_ff        <= wpos_in;
      copy_ff        <= copy_in;
      bit_ff         <= bit_in;
      grp_ff         <= grp_in;
      pat_ff         <= pat_in;
      rsp_pattern_ff <= rsp_pattern_in;
      rsp_code_ff    <= rsp_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pattern_bits = rsp_pattern_ff;
   assign rsp_length_code  = rsp_code_ff;

`ifndef SYNTHESIS
   a_cnt1_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> (cnt1_ff != '0) && (cnt1_ff <= len_ff))
      else $error("merge round started with a pulse count outside 1..length");

   a_round_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (round_ff < MaxLen))
      else $error("merge round taken past the round limit");

   a_wpos_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |-> (erpg_pkg::FIELD_W'(wpos_ff) < len_ff) && (pos_ff < len_ff))
      else $error("serializer wrote outside the pattern length");

   a_result_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (((2*erpg_pkg::PATTERN_W)'(rsp_pattern_ff) >>
           ((rsp_code_ff == '0) ? erpg_pkg::PATTERN_W : int'(rsp_code_ff))) == '0))
      else $error("result holds a note at or above its length");
`endif

endmodule

### rtl/euclidean_rhythm_pattern_generator_core.sv
// Top level of the Euclidean rhythm pattern generator.
`timescale 1ns / 1ps

// Each request beat carries a pattern length, a pulse count and a rotation; the block
// answers with exactly one response beat holding a 16-bit rhythm (bit i set means a
// note at step i) and a 4-bit length code in which a length of 16 reads as 0. A length
// of 0 is taken as 1, a length above 16 as 16, and the pulse count is clamped to
// 1..length. The block handles one request at a time: it takes a request only while the
// sequencer is idle, and the finished result sits in an output register, so a new
// request is taken while the previous response still waits for rsp_tready. A request
// is accepted, then the rotation is reduced by repeated subtraction, then merge rounds
// run, the final stopping round included, each made of a multiply, a dividend set-up,
// four restoring-division steps and the group update; serialization follows at one
// step per cycle, and the result is loaded into the output register. Dense patterns
// stop merging after one or two rounds; sparse patterns need about one merge round
// per step. A short length with a large rotation needs the most subtraction steps.

module euclidean_rhythm_pattern_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] pattern_length, [9:5] pulse_count, [14:10] rotation, [15] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] pattern_bits, [19:16] length_code, [23:20] zero
   output logic [23:0] rsp_tdata
);

   erpg_pkg::erpg_cmd_type cmd;
   erpg_pkg::erpg_sts_type sts;
   logic                   idle;

   logic [erpg_pkg::PATTERN_W-1:0] pattern_bits;
   logic [erpg_pkg::CODE_W-1:0]    length_code;

   // The controller walks through rotation reduction, merge rounds and serialization.
   erpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .sts       (sts),
      .cmd       (cmd),
      .idle      (idle)
   );

   // The datapath holds the groups, the small divider, the serializer and the
   // output register.
   erpg_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_pattern_length (req_tdata[4:0]),
      .req_pulse_count    (req_tdata[9:5]),
      .req_rotation       (req_tdata[14:10]),
      .rsp_ready          (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_pattern_bits   (pattern_bits),
      .rsp_length_code    (length_code)
   );

   // A request beat is taken only while the sequencer is idle.
   assign req_tready = idle;
   assign rsp_tdata  = {4'b0, length_code, pattern_bits};

endmodule

### bench/euclidean_rhythm_pattern_generator_core_tb.sv
// Self-checking testbench for the Euclidean rhythm pattern generator core.
`timescale 1ns / 1ps

module euclidean_rhythm_pattern_generator_core_tb;

   // Cycles with no beat on either side before the run is declared hung.
   localparam int STALL_LIMIT      = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 120;

   typedef struct packed {
      logic [erpg_pkg::PATTERN_W-1:0] bits;
      logic [erpg_pkg::CODE_W-1:0]    code;
   } rhythm_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [4:0] pattern_length, [9:5] pulse_count, [14:10] rotation, [15] zero
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [15:0] pattern_bits, [19:16] length_code, [23:20] zero
   logic [23:0] rsp_tdata;

   rhythm_beat_type pending_rhythms[$];
   rhythm_beat_type want;
   int              requests_sent;
   int              rhythms_checked;
   int              fail_count;
   int              quiet_cycles;
   bit              tx_gaps;
   bit              rx_gaps;
   bit              long_hold;

   euclidean_rhythm_pattern_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bit length of a group: index of the highest set bit plus one, never below one.
   function automatic int group_size(input logic [31:0] grp);
      int n;
      n = 1;
      for (int i = 0; i < 32; i++) begin
         if (grp[i]) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

   // Expected rhythm for one request: clamp the fields, merge the two groups until
   // the second group's count drops to one or less or the round limit is hit, lay the
   // groups out from bit 0 upward, then rotate left within the effective length.
   function automatic rhythm_beat_type predict_rhythm(input logic [4:0] len_f,
                                                     input logic [4:0] pulses_f,
                                                     input logic [4:0] rot_f);
      int              steps;
      int              notes;
      int              shift;
      int              s1;
      int              s2;
      int              cnt1;
      int              cnt2;
      int              pos;
      int              size;
      int              copies;
      logic [31:0]     g1;
      logic [31:0]     g2;
      logic [31:0]     grp;
      logic [31:0]     old1;
      logic [31:0]     low;
      logic [31:0]     pat;
      logic [31:0]     mask;
      rhythm_beat_type r;

      steps = len_f;
      if (steps == 0) begin
         steps = 1;
      end
      if (steps > erpg_pkg::MAX_STEPS) begin
         steps = erpg_pkg::MAX_STEPS;
      end
      notes = pulses_f;
      if (notes == 0) begin
         notes = 1;
      end
      if (notes > steps) begin
         notes = steps;
      end

      g1   = 32'd1;
      g2   = 32'd0;
      cnt1 = notes;
      pat  = 32'd0;
      for (int rnd = 0; rnd <= erpg_pkg::MAX_STEPS; rnd++) begin
         s1   = group_size(g1);
         s2   = group_size(g2);
         cnt2 = (steps - cnt1 * s1) / s2;
         if (cnt2 <= 1 || rnd >= erpg_pkg::MAX_STEPS) begin
            pos = 0;
            for (int k = 0; k < 2; k++) begin
               grp    = (k == 0) ? g1 : g2;
               size   = (k == 0) ? s1 : s2;
               copies = (k == 0) ? cnt1 : cnt2;
               for (int c = 0; c < copies; c++) begin
                  for (int b = size - 1; b >= 0; b--) begin
                     if (grp[b] && pos < 16) begin
                        pat[pos] = 1'b1;
                     end
                     pos++;
                  end
               end
            end
            break;
         end
         old1 = g1;
         low  = g2 & ((32'd1 << s2) - 32'd1);
         g1   = ((g1 << s2) | low) & 32'h0000ffff;
         if (cnt2 - cnt1 <= 0) begin
            g2 = old1;
         end
         if (cnt2 < cnt1) begin
            cnt1 = cnt2;
         end
      end

      mask  = (32'd1 << steps) - 32'd1;
      pat   = pat & mask & 32'h0000ffff;
      shift = rot_f % steps;
      if (shift != 0) begin
         pat = ((pat << shift) | (pat >> (steps - shift))) & mask;
      end
      r.bits = pat[15:0];
      r.code = (steps == erpg_pkg::MAX_STEPS) ? '0 : erpg_pkg::CODE_W'(steps);
      return r;
   endfunction

   // Offers one request beat and waits for it to be taken. The valid stays high
   // afterwards unless a gap is drawn, so back-to-back beats need no re-raise.
   task automatic send_request(input logic [4:0] len_f, input logic [4:0] pulses_f,
                               input logic [4:0] rot_f);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rot_f, pulses_f, len_f};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_rhythms.push_back(predict_rhythm(len_f, pulses_f, rot_f));
      requests_sent++;
      if (tx_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Drops the valid and waits until every predicted rhythm has come back.
   task automatic drain_rhythms();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rhythms.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Field extremes, clamping of the length and pulse fields, rotation wrap, and classic rhythms.
   task automatic test_directed();
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      send_request(5'd0, 5'd0, 5'd0);      // zero length and zero pulses
      send_request(5'd0, 5'd5, 5'd7);
      send_request(5'd1, 5'd1, 5'd0);
      send_request(5'd16, 5'd16, 5'd0);    // every step a note
      send_request(5'd16, 5'd0, 5'd31);
      send_request(5'd17, 5'd3, 5'd2);     // length above the maximum saturates
      send_request(5'd31, 5'd31, 5'd31);
      send_request(5'd16, 5'd5, 5'd0);
      send_request(5'd8, 5'd3, 5'd0);
      send_request(5'd8, 5'd3, 5'd1);
      send_request(5'd8, 5'd3, 5'd8);      // rotation equal to the length
      send_request(5'd8, 5'd3, 5'd31);     // rotation far above the length
      send_request(5'd5, 5'd2, 5'd0);
      send_request(5'd7, 5'd3, 5'd0);
      send_request(5'd12, 5'd5, 5'd3);
      send_request(5'd13, 5'd5, 5'd0);
      send_request(5'd16, 5'd7, 5'd15);
      send_request(5'd16, 5'd1, 5'd0);
      send_request(5'd16, 5'd15, 5'd0);
      send_request(5'd9, 5'd4, 5'd20);
      send_request(5'd15, 5'd8, 5'd0);
      send_request(5'd2, 5'd1, 5'd1);
      send_request(5'd3, 5'd31, 5'd2);     // pulses above the length
      send_request(5'd11, 5'd10, 5'd5);
      send_request(5'd16, 5'd9, 5'd16);
      drain_rhythms();
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so the
   // result register stays full and the request side must stall.
   task automatic test_backpressure();
      tx_gaps   = 1'b0;
      rx_gaps   = 1'b0;
      long_hold = 1'b1;
      for (int i = 0; i < 12; i++) begin
         send_request(5'($urandom_range(1, 16)), 5'($urandom_range(0, 16)),
                      5'($urandom_range(0, 31)));
      end
      drain_rhythms();
   endtask

   // Short bursts separated by full drains, so each burst starts on an idle block.
   task automatic test_burst_then_drain();
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      for (int burst = 0; burst < 4; burst++) begin
         for (int i = 0; i < 4; i++) begin
            send_request(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                         5'($urandom_range(0, 31)));
         end
         drain_rhythms();
      end
   endtask

   // Mostly legal lengths with random pulses and rotations, plus raw field noise.
   task automatic test_random(input int count, input bit with_gaps);
      logic [4:0] len_f;
      logic [4:0] pulses_f;
      logic [4:0] rot_f;
      int         mode;
      for (int i = 0; i < count; i++) begin
         if (with_gaps && i % 100 == 0) begin
            mode    = $urandom_range(0, 3);
            tx_gaps = mode[0];
            rx_gaps = mode[1];
         end
         if ($urandom_range(0, 9) < 8) begin
            len_f    = 5'($urandom_range(1, 16));
            pulses_f = 5'($urandom_range(0, int'(len_f) + 1));
            rot_f    = 5'($urandom_range(0, 31));
         end else begin
            len_f    = 5'($urandom_range(0, 31));
            pulses_f = 5'($urandom_range(0, 31));
            rot_f    = 5'($urandom_range(0, 31));
         end
         send_request(len_f, pulses_f, rot_f);
      end
   endtask

   // Receiver: random ready bursts, plus the long hold that the pressure test asks for.
   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every response beat is matched against the oldest predicted rhythm.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rhythms.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response beat, actual data %h", $time, rsp_tdata);
         end else begin
            want = pending_rhythms.pop_front();
            rhythms_checked++;
            if (rsp_tdata[15:0] !== want.bits) begin
               fail_count++;
               $display("%0t: pattern_bits expected %h actual %h",
                        $time, want.bits, rsp_tdata[15:0]);
            end
            if (rsp_tdata[19:16] !== want.code) begin
               fail_count++;
               $display("%0t: length_code expected %0d actual %0d",
                        $time, want.code, rsp_tdata[19:16]);
            end
            if (rsp_tdata[23:20] !== 4'd0) begin
               fail_count++;
               $display("%0t: padding bits expected 0 actual %h", $time, rsp_tdata[23:20]);
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither side moves a beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d rhythms outstanding",
                     $time, STALL_LIMIT, pending_rhythms.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      tx_gaps         = 1'b0;
      rx_gaps         = 1'b0;
      long_hold       = 1'b0;
      requests_sent   = 0;
      rhythms_checked = 0;
      fail_count      = 0;
      quiet_cycles    = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_burst_then_drain();
      test_random(950, 1'b1);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      test_random(150, 1'b0);

      drain_rhythms();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d rhythms, %0d mismatches.",
               requests_sent, rhythms_checked, fail_count);
      $display("Covered clamped and saturated fields, long receiver holds and drains.");
      if (fail_count == 0 && pending_rhythms.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
